/* src/encode_time_quality_governor_assert.svh */
// assertion helpers for the encode time quality governor
`ifndef ENCODE_TIME_QUALITY_GOVERNOR_ASSERT_SVH
`define ENCODE_TIME_QUALITY_GOVERNOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ETQG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ETQG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/etqg_pkg.sv */
// -----------------------------------------------------------------------------
// etqg_pkg
// Shared widths, constants, codes and control and status structs of the governor.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package etqg_pkg;

   localparam int WINDOW    = 30;
   localparam int SAMPLE_W  = 24;
   localparam int TARGET_W  = 20;
   localparam int MEAN_W    = 24;
   localparam int STEP_W    = 2;
   localparam int STREAK_W  = 3;
   localparam int OP_W      = 2;
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W     = SAMPLE_W + CNT_W;
   localparam int ITER_W    = $clog2(SUM_W + 1);
   // widest scaled term is 20 times the mean
   localparam int SCL_W     = MEAN_W + 5;

   localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(41667);
   localparam logic [STREAK_W-1:0] STREAK_LIMIT = STREAK_W'(5);
   localparam logic [STEP_W-1:0]   STEP_MAX     = STEP_W'(2);

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE       = 2'd0,
      OP_CLR_FALLBACK = 2'd1,
      OP_RESTART      = 2'd2,
      OP_RESTART_KEEP = 2'd3
   } op_type;

   typedef struct packed {
      logic rd;
      logic upd;
      logic clr;
   } win_ctl_type;

   typedef struct packed {
      logic   load;
      logic   apply;
      op_type op;
   } pol_ctl_type;

   typedef struct packed {
      logic [STEP_W-1:0]   step;
      logic                q_changed;
      logic                fast;
      logic                m_changed;
      logic                fallback;
      logic [STREAK_W-1:0] streak;
   } pol_stat_type;

endpackage

`default_nettype wire

/* src/etqg_if.sv */
// -----------------------------------------------------------------------------
// etqg_if
// Valid/ready channels for request words and result words.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface etqg_req_if;
   logic                          valid;
   logic                          ready;
   logic [etqg_pkg::OP_W-1:0]     operation;
   logic [etqg_pkg::SAMPLE_W-1:0] sample_us;

   modport source (output valid, output operation, output sample_us, input ready);
   modport sink   (input valid, input operation, input sample_us, output ready);
endinterface

interface etqg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [etqg_pkg::MEAN_W-1:0]   average_us;
   logic [etqg_pkg::STEP_W-1:0]   quality_step;
   logic                          quality_changed;
   logic                          fast_mode;
   logic                          mode_changed;
   logic                          fallback_request;
   logic [etqg_pkg::STREAK_W-1:0] streak;

   modport source (output valid, output average_us, output quality_step,
                   output quality_changed, output fast_mode, output mode_changed,
                   output fallback_request, output streak, input ready);
   modport sink   (input valid, input average_us, input quality_step,
                   input quality_changed, input fast_mode, input mode_changed,
                   input fallback_request, input streak, output ready);
endinterface

`default_nettype wire

/* src/etqg_window.sv */
// -----------------------------------------------------------------------------
// etqg_window
// Sample ring memory with write pointer, fill count and running sum.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module etqg_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire etqg_pkg::win_ctl_type         ctl,
   input  wire logic [etqg_pkg::SAMPLE_W-1:0] sample,
   output logic      [etqg_pkg::SUM_W-1:0]    sum,
   output logic      [etqg_pkg::CNT_W-1:0]    count
);
   import etqg_pkg::*;

   logic [SAMPLE_W-1:0] store_mem [WINDOW];
   logic [SAMPLE_W-1:0] old_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;
   logic                full;

   assign full = (count_ff == CNT_W'(WINDOW));

   // read in the cycle before the write to the same entry
   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         old_ff <= store_mem[pos_ff];
      end
      if (ctl.upd) begin
         store_mem[pos_ff] <= sample;
      end
   end

   always_comb begin
      sum_in   = sum_ff - (full ? SUM_W'(old_ff) : '0) + SUM_W'(sample);
      count_in = full ? count_ff : count_ff + CNT_W'(1);
      pos_in   = (pos_ff == POS_W'(WINDOW - 1)) ? '0 : pos_ff + POS_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clr) begin
         pos_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (ctl.upd) begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   assign sum   = sum_ff;
   assign count = count_ff;

endmodule

`default_nettype wire

/* src/etqg_divider.sv */
// -----------------------------------------------------------------------------
// etqg_divider
// Restoring divider, one quotient bit per cycle, for the window mean.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module etqg_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [etqg_pkg::SUM_W-1:0] dividend,
   input  wire logic [etqg_pkg::CNT_W-1:0] divisor,
   output logic                            done,
   output logic      [etqg_pkg::SUM_W-1:0] quotient
);
   import etqg_pkg::*;

   logic [SUM_W-1:0]  quo_ff;
   logic [SUM_W-1:0]  quo_in;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  rem_in;
   logic [CNT_W-1:0]  div_ff;
   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    diff;
   logic              ge;
   logic [ITER_W-1:0] iter_ff;
   logic              busy_ff;
   logic              done_ff;

   // dividend bits shift out the top while quotient bits shift in below
   always_comb begin
      rem_sh = {rem_ff, quo_ff[SUM_W-1]};
      ge     = (rem_sh >= {1'b0, div_ff});
      diff   = rem_sh - {1'b0, div_ff};
      rem_in = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_in = {quo_ff[SUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= ITER_W'(SUM_W);
         end else if (busy_ff) begin
            iter_ff <= iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* src/etqg_policy.sv */
// -----------------------------------------------------------------------------
// etqg_policy
// Quality step, preset mode with hysteresis, streak and fallback flag.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module etqg_policy (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire etqg_pkg::pol_ctl_type         ctl,
   input  wire logic [etqg_pkg::MEAN_W-1:0]   mean,
   input  wire logic [etqg_pkg::TARGET_W-1:0] target,
   output etqg_pkg::pol_stat_type             stat
);
   import etqg_pkg::*;

   // scaled terms, registered ahead of the compares
   logic [SCL_W-1:0]    m1_ff, m2_ff, m5_ff, m8_ff, m20_ff;
   logic [SCL_W-1:0]    t1_ff, t3_ff, t5_ff, t7_ff, t17_ff;

   logic [STEP_W-1:0]   step_ff, step_in;
   logic                fast_ff, fast_in;
   logic [STREAK_W-1:0] streak_ff, streak_in, streak_nx;
   logic                fallback_ff, fallback_in;
   logic                q_chg_ff, q_chg_in;
   logic                m_chg_ff, m_chg_in;
   logic [STEP_W-1:0]   step_new;
   logic                fast_new;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         m1_ff  <= SCL_W'(mean);
         m2_ff  <= SCL_W'(mean) << 1;
         m5_ff  <= (SCL_W'(mean) << 2) + SCL_W'(mean);
         m8_ff  <= SCL_W'(mean) << 3;
         m20_ff <= (SCL_W'(mean) << 4) + (SCL_W'(mean) << 2);
         t1_ff  <= SCL_W'(target);
         t3_ff  <= (SCL_W'(target) << 1) + SCL_W'(target);
         t5_ff  <= (SCL_W'(target) << 2) + SCL_W'(target);
         t7_ff  <= (SCL_W'(target) << 3) - SCL_W'(target);
         t17_ff <= (SCL_W'(target) << 4) + SCL_W'(target);
      end
   end

   always_comb begin
      priority if (m2_ff <= t1_ff) begin
         step_new = '0;
      end else if (m8_ff >= t7_ff) begin
         step_new = STEP_MAX;
      end else if (m8_ff >= t5_ff) begin
         step_new = STEP_W'(1);
      end else begin
         step_new = '0;
      end

      priority if (m2_ff < t1_ff) begin
         fast_new = 1'b0;
      end else if (m20_ff >= t17_ff) begin
         fast_new = 1'b1;
      end else begin
         fast_new = fast_ff;
      end

      priority if (m1_ff > t1_ff) begin
         streak_nx = streak_ff + STREAK_W'(1);
      end else if (m5_ff < t3_ff && streak_ff != '0) begin
         streak_nx = streak_ff - STREAK_W'(1);
      end else begin
         streak_nx = streak_ff;
      end

      step_in     = step_ff;
      fast_in     = fast_ff;
      streak_in   = streak_ff;
      fallback_in = fallback_ff;
      q_chg_in    = 1'b0;
      m_chg_in    = 1'b0;

      unique case (ctl.op)
         OP_SAMPLE: begin
            step_in  = step_new;
            fast_in  = fast_new;
            q_chg_in = (step_new != step_ff);
            m_chg_in = (fast_new != fast_ff);
            if (streak_nx == STREAK_LIMIT) begin
               fallback_in = 1'b1;
               streak_in   = '0;
            end else begin
               streak_in   = streak_nx;
            end
         end
         OP_CLR_FALLBACK: begin
            fallback_in = 1'b0;
         end
         OP_RESTART: begin
            step_in     = '0;
            fast_in     = 1'b0;
            streak_in   = '0;
            fallback_in = 1'b0;
         end
         OP_RESTART_KEEP: begin
            streak_in   = '0;
            fallback_in = 1'b0;
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= '0;
         fast_ff     <= 1'b0;
         streak_ff   <= '0;
         fallback_ff <= 1'b0;
         q_chg_ff    <= 1'b0;
         m_chg_ff    <= 1'b0;
      end else if (ctl.apply) begin
         step_ff     <= step_in;
         fast_ff     <= fast_in;
         streak_ff   <= streak_in;
         fallback_ff <= fallback_in;
         q_chg_ff    <= q_chg_in;
         m_chg_ff    <= m_chg_in;
      end
   end

   always_comb begin
      stat.step      = step_ff;
      stat.q_changed = q_chg_ff;
      stat.fast      = fast_ff;
      stat.m_changed = m_chg_ff;
      stat.fallback  = fallback_ff;
      stat.streak    = streak_ff;
   end

endmodule

`default_nettype wire

/* src/encode_time_quality_governor.sv */
// -----------------------------------------------------------------------------
// encode_time_quality_governor
// Encode time governor: window mean, quality step, preset mode and fallback.
// -----------------------------------------------------------------------------
// Usage:
//  req_ch carries one word per operation: a sample of encode time in
//  microseconds, a fallback clear, a full restart or a restart that keeps
//  the quality step and preset mode. rsp_ch returns exactly one word per
//  request with the window mean and the governor state after it.
//  csr_we/csr_wdata write the frame time budget; write it only while idle.
//  A sample passes through the window read and update, the serial divider
//  forming the window mean (one quotient bit per cycle), the scaling and
//  the policy update; other operations go straight to the policy update.
//  One word is in flight at a time; req_ch.ready returns the cycle after a
//  result is loaded into the output register.
//  A stalled rsp_ch holds its word; the next request is still taken and
//  worked on, then waits until the output register frees up.
//  Reset clears the window, the step, the mode, the streak and the flag,
//  and sets the budget to 41667 us. The sample memory needs no clearing.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "encode_time_quality_governor_assert.svh"

module encode_time_quality_governor (
   input  wire logic                          clock,
   input  wire logic                          reset,
   etqg_req_if.sink                           req_ch,
   etqg_rsp_if.source                         rsp_ch,
   input  wire logic                          csr_we,
   input  wire logic [etqg_pkg::TARGET_W-1:0] csr_wdata
);
   import etqg_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_UPDATE,
      S_DIVGO,
      S_DIV,
      S_SCALE,
      S_APPLY,
      S_OUT
   } state_type;

   state_type           state_ff;
   op_type              op_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [MEAN_W-1:0]   mean_ff;
   logic [TARGET_W-1:0] target_ff;

   logic                rsp_valid_ff;
   logic [MEAN_W-1:0]   rsp_avg_ff;
   pol_stat_type        rsp_stat_ff;

   win_ctl_type         win_ctl;
   pol_ctl_type         pol_ctl;
   pol_stat_type        pol_stat;
   logic [SUM_W-1:0]    win_sum;
   logic [CNT_W-1:0]    win_count;
   logic                div_start;
   logic                div_done;
   logic [SUM_W-1:0]    div_quo;

   logic                stat_ok;
   logic                out_held;
   logic                out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
      end else if (csr_we) begin
         target_ff <= csr_wdata;
      end
   end

   always_comb begin
      win_ctl.rd    = (state_ff == S_READ);
      win_ctl.upd   = (state_ff == S_UPDATE);
      win_ctl.clr   = (state_ff == S_APPLY) &&
                      (op_ff == OP_RESTART || op_ff == OP_RESTART_KEEP);
      pol_ctl.load  = (state_ff == S_SCALE);
      pol_ctl.apply = (state_ff == S_APPLY);
      pol_ctl.op    = op_ff;
      div_start     = (state_ff == S_DIVGO);
   end

   etqg_window u_window (
      .clock  (clock),
      .reset  (reset),
      .ctl    (win_ctl),
      .sample (sample_ff),
      .sum    (win_sum),
      .count  (win_count)
   );

   etqg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (win_sum),
      .divisor  (win_count),
      .done     (div_done),
      .quotient (div_quo)
   );

   etqg_policy u_policy (
      .clock  (clock),
      .reset  (reset),
      .ctl    (pol_ctl),
      .mean   (mean_ff),
      .target (target_ff),
      .stat   (pol_stat)
   );

   assign req_ch.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mean_ff      <= '0;
      end else begin
         // in S_OUT the load below owns the valid flag
         if (rsp_ch.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  op_ff     <= op_type'(req_ch.operation);
                  sample_ff <= req_ch.sample_us;
                  state_ff  <= (op_type'(req_ch.operation) == OP_SAMPLE) ? S_READ
                                                                          : S_APPLY;
               end
            end
            S_READ: begin
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               state_ff <= S_DIVGO;
            end
            S_DIVGO: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  mean_ff  <= div_quo[MEAN_W-1:0];
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               // restarts empty the window, so the mean drops to zero
               if (op_ff == OP_RESTART || op_ff == OP_RESTART_KEEP) begin
                  mean_ff <= '0;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_avg_ff   <= mean_ff;
                  rsp_stat_ff  <= pol_stat;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.average_us       = rsp_avg_ff;
   assign rsp_ch.quality_step     = rsp_stat_ff.step;
   assign rsp_ch.quality_changed  = rsp_stat_ff.q_changed;
   assign rsp_ch.fast_mode        = rsp_stat_ff.fast;
   assign rsp_ch.mode_changed     = rsp_stat_ff.m_changed;
   assign rsp_ch.fallback_request = rsp_stat_ff.fallback;
   assign rsp_ch.streak           = rsp_stat_ff.streak;

   assign stat_ok   = (pol_stat.streak < STREAK_LIMIT) && (pol_stat.step <= STEP_MAX);
   assign out_held  = (state_ff == S_OUT) && rsp_valid_ff;
   assign out_stall = out_held && !rsp_ch.ready;

   `ETQG_ASSERT_IMP(a_div_done, clock, reset, div_done, state_ff == S_DIV, "stray divide done")
   `ETQG_ASSERT_IMP(a_stat_range, clock, reset, 1'b1, stat_ok, "streak or step out of range")
   `ETQG_ASSERT_NEXT(a_stall_hold, clock, reset, out_stall, out_held, "result word lost in stall")

endmodule

`default_nettype wire
